// File: design/sasc_pkg.sv
// ----------------------------------------------------------------------------
// sasc_pkg: shared constants and codes of the spike classifier
// Field widths, configuration register indexes, result kinds and reject codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sasc_pkg;

    // Default widths for the top-level parameters
    localparam int TIME_BITS_DEF   = 48;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths
    localparam int CHANNEL_W = 8;
    localparam int UNIT_W    = 3;
    localparam int WORD_W    = 16;
    localparam int KIND_W    = 2;
    localparam int REJ_W     = 2;
    localparam int CMD_W     = 1;

    // Snippet sample groups used by the shape check
    localparam int N_EARLY = 5;
    localparam int N_LATE  = 2;

    // Configuration registers
    localparam int BLANK_W    = 12;
    localparam int WINDOW_W   = 12;
    localparam int PRE_W      = 6;
    localparam int MASK_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_TICKS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MASK    = 2'd3;

    localparam logic [BLANK_W-1:0]  BLANK_RST  = 12'd30;
    localparam logic [WINDOW_W-1:0] WINDOW_RST = 12'd180;
    localparam logic [PRE_W-1:0]    PRE_RST    = 6'd11;
    localparam logic [MASK_W-1:0]   MASK_RST   = 16'd0;

    // Item kinds on the input side
    localparam logic [CMD_W-1:0] CMD_SPIKE   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DIGITAL = 1'b1;

    // Digital event counter saturates here
    localparam logic [1:0] DIG_COUNT_SAT = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPT  = 2'd0,
        KIND_REJECT  = 2'd1,
        KIND_SYNC    = 2'd2,
        KIND_DIGITAL = 2'd3
    } t_kind;

    typedef enum logic [REJ_W-1:0] {
        REJ_NONE      = 2'd0,
        REJ_PRIMARY   = 2'd1,
        REJ_SECONDARY = 2'd2
    } t_reject;

endpackage

`default_nettype wire

// File: design/sasc_shape_check.sv
// ----------------------------------------------------------------------------
// sasc_shape_check: snippet shape test for secondary artifacts
// Passes when the truncated mean of the early samples is strictly greater
// than the truncated mean of the two late samples. No divider: the test
// trunc(early_sum / N) > m is rewritten as a compare against a bound on k = m + 1.
// ----------------------------------------------------------------------------
`default_nettype none

module sasc_shape_check #(
    parameter int SAMPLE_BITS = sasc_pkg::SAMPLE_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0] i_early [sasc_pkg::N_EARLY],
    input  logic signed [SAMPLE_BITS-1:0] i_late  [sasc_pkg::N_LATE],
    output logic                          o_shape_ok
);

    localparam int CW = SAMPLE_BITS + 4;

    logic signed [CW-1:0] early_sum;
    logic signed [CW-1:0] late_sum;
    logic signed [CW-1:0] late_adj;
    logic signed [CW-1:0] late_mean;
    logic signed [CW-1:0] k_val;
    logic signed [CW-1:0] k_scaled;
    logic signed [CW-1:0] bound;

    always_comb begin
        early_sum = '0;
        for (int i = 0; i < sasc_pkg::N_EARLY; i++) begin
            early_sum = early_sum + CW'(i_early[i]);
        end
        late_sum = '0;
        for (int j = 0; j < sasc_pkg::N_LATE; j++) begin
            late_sum = late_sum + CW'(i_late[j]);
        end
        // truncate toward zero: bias negative sums by one before the shift
        late_adj  = late_sum + {{(CW-1){1'b0}}, late_sum[CW-1]};
        late_mean = late_adj >>> 1;
        k_val     = late_mean + CW'(1);
        k_scaled  = CW'(k_val * CW'(sasc_pkg::N_EARLY));
        // positive k needs early_sum >= N*k, otherwise early_sum >= N*k - (N-1)
        if (k_val > 0) begin
            bound = k_scaled;
        end else begin
            bound = k_scaled - CW'(sasc_pkg::N_EARLY - 1);
        end
        o_shape_ok = (early_sum >= bound);
    end

endmodule

`default_nettype wire

// File: design/stim_artifact_spike_classifier_core.sv
// ----------------------------------------------------------------------------
// stim_artifact_spike_classifier_core: stimulus artifact spike classifier
// Classifies spikes against the last stimulus sync time and turns digital
// input words into sync and digital edge events.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream i_s_*: one item per handshake, tuser selects spike (0) or
//   digital word (1); tdata carries time, channel, unit, snippet samples and
//   the digital word. Master stream o_m_*: result items, tuser is the kind,
//   tlast marks the final result of an input item.
//   A spike gives exactly one result; a digital word gives zero, one (sync or
//   digital) or two (sync, then digital) results.
//   An accepted item is held in the input register; its first result moves
//   into the output register, which drives o_m_*, once that is free.
//   Throughput: one item per cycle while the output is not stalled; a digital
//   word with two results holds its second result in the pending register,
//   and the next item waits in the input register until that result moves up.
//   The input register holds one item while the output register waits, so a
//   new item is taken while a result stalls; when both are full, o_s_tready
//   drops until the receiver takes the result.
//   Configuration writes through i_cfg_* take effect at the next edge; the user
//   must make them only while the block is idle; the block does not enforce this.
//   Reset (synchronous, active low) empties the input, output and pending
//   registers, loads the default register values and clears the artifact
//   time and digital edge state.
// ----------------------------------------------------------------------------
`default_nettype none

module stim_artifact_spike_classifier_core #(
    parameter int TIME_BITS   = sasc_pkg::TIME_BITS_DEF,
    parameter int SAMPLE_BITS = sasc_pkg::SAMPLE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // configuration write port
    input  logic                             i_cfg_wr_en,
    input  logic [sasc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sasc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,

    // input items
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // tdata, lowest bit up: event_time, channel, unit, early_sample_0..4,
    // late_sample_10, late_sample_11, dig_word, zero fill
    input  logic [((TIME_BITS + sasc_pkg::CHANNEL_W + sasc_pkg::UNIT_W
                    + (sasc_pkg::N_EARLY + sasc_pkg::N_LATE) * SAMPLE_BITS
                    + sasc_pkg::WORD_W + 7) / 8) * 8 - 1:0] i_s_tdata,
    // tuser: cmd
    input  logic [sasc_pkg::CMD_W-1:0] i_s_tuser,

    // result items
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // tdata, lowest bit up: reject_type, out_time, out_channel, out_unit,
    // out_word, zero fill
    output logic [((sasc_pkg::REJ_W + TIME_BITS + sasc_pkg::CHANNEL_W
                    + sasc_pkg::UNIT_W + sasc_pkg::WORD_W + 7) / 8) * 8 - 1:0] o_m_tdata,
    // tuser: kind
    output logic [sasc_pkg::KIND_W-1:0] o_m_tuser,
    output logic                        o_m_tlast
);

    localparam int CH_W   = sasc_pkg::CHANNEL_W;
    localparam int UN_W   = sasc_pkg::UNIT_W;
    localparam int WD_W   = sasc_pkg::WORD_W;
    localparam int NE     = sasc_pkg::N_EARLY;
    localparam int NL     = sasc_pkg::N_LATE;
    localparam int BL_W   = sasc_pkg::BLANK_W;
    localparam int OFF_CH    = TIME_BITS;
    localparam int OFF_UNIT  = OFF_CH + CH_W;
    localparam int OFF_EARLY = OFF_UNIT + UN_W;
    localparam int OFF_LATE  = OFF_EARLY + NE * SAMPLE_BITS;
    localparam int OFF_WORD  = OFF_LATE + NL * SAMPLE_BITS;
    localparam int OUT_W = ((sasc_pkg::REJ_W + TIME_BITS + CH_W + UN_W + WD_W + 7) / 8) * 8;
    localparam int D_W   = BL_W + 2;

    typedef struct packed {
        logic [sasc_pkg::CMD_W-1:0]            cmd;
        logic [TIME_BITS-1:0]                  event_time;
        logic [CH_W-1:0]                       channel;
        logic [UN_W-1:0]                       unit;
        logic [NE-1:0][SAMPLE_BITS-1:0]        early;
        logic [NL-1:0][SAMPLE_BITS-1:0]        late;
        logic [WD_W-1:0]                       dig_word;
    } t_item;

    typedef struct packed {
        sasc_pkg::t_kind   kind;
        sasc_pkg::t_reject rej;
        logic [TIME_BITS-1:0] out_time;
        logic [CH_W-1:0]      channel;
        logic [UN_W-1:0]      unit;
        logic [WD_W-1:0]      word;
        logic                 last;
    } t_result;

    // configuration
    logic [sasc_pkg::BLANK_W-1:0]  r_blank_ticks;
    logic [sasc_pkg::WINDOW_W-1:0] r_window_ticks;
    logic [sasc_pkg::PRE_W-1:0]    r_pre_ticks;
    logic [sasc_pkg::MASK_W-1:0]   r_sync_mask;

    // classifier state
    logic [TIME_BITS-1:0] r_artifact_time;
    logic [WD_W-1:0]      r_prev_raw;
    logic [WD_W-1:0]      r_prev_edge;
    logic [1:0]           r_dig_count;

    // pipeline
    logic    r_s1_valid;
    t_item   r_s1;
    t_item   n_s1;
    logic    r_out_valid;
    t_result r_out;
    logic    r_pend_valid;
    t_result r_pend;

    logic adv;
    logic out_free;
    logic s_accept;

    // spike offset
    logic [TIME_BITS:0]      diff;
    logic                    near;
    logic signed [D_W-1:0]   d_off;
    logic                    pos;
    logic                    primary;
    logic                    secondary;
    logic                    shape_ok;
    logic signed [SAMPLE_BITS-1:0] early_s [NE];
    logic signed [SAMPLE_BITS-1:0] late_s  [NL];

    // digital edge logic
    logic [WD_W-1:0] risen;
    logic [WD_W-1:0] risen_clr;
    logic            stim;
    logic            dig_ev;
    logic            is_spike;

    t_result res_a;
    t_result res_b;
    logic    two_res;
    logic    any_res;

    // ------------------------------------------------------------------
    // Input unpacking and handshake
    // ------------------------------------------------------------------
    always_comb begin
        n_s1.cmd        = i_s_tuser;
        n_s1.event_time = i_s_tdata[0 +: TIME_BITS];
        n_s1.channel    = i_s_tdata[OFF_CH +: CH_W];
        n_s1.unit       = i_s_tdata[OFF_UNIT +: UN_W];
        for (int i = 0; i < NE; i++) begin
            n_s1.early[i] = i_s_tdata[OFF_EARLY + i * SAMPLE_BITS +: SAMPLE_BITS];
        end
        for (int j = 0; j < NL; j++) begin
            n_s1.late[j] = i_s_tdata[OFF_LATE + j * SAMPLE_BITS +: SAMPLE_BITS];
        end
        n_s1.dig_word   = i_s_tdata[OFF_WORD +: WD_W];
    end

    assign out_free   = !r_out_valid || i_m_tready;
    // a pending second result must drain before the next item moves on
    assign adv        = r_s1_valid && out_free && !r_pend_valid;
    assign o_s_tready = !r_s1_valid || adv;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // ------------------------------------------------------------------
    // Spike classification
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < NE; i++) begin
            early_s[i] = signed'(r_s1.early[i]);
        end
        for (int j = 0; j < NL; j++) begin
            late_s[j] = signed'(r_s1.late[j]);
        end
    end

    sasc_shape_check #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_shape (
        .i_early    (early_s),
        .i_late     (late_s),
        .o_shape_ok (shape_ok)
    );

    always_comb begin
        diff = {1'b0, r_s1.event_time} - {1'b0, r_artifact_time};
        // offsets outside a small signed range never reach either window
        near = (diff[TIME_BITS:BL_W] == '0) || (&diff[TIME_BITS:BL_W]);
        d_off = signed'({diff[BL_W], diff[BL_W:0]})
              + signed'({{(D_W - sasc_pkg::PRE_W){1'b0}}, r_pre_ticks});
        pos   = near && (d_off > 0);
        primary   = pos && (d_off <= signed'({2'b00, r_blank_ticks}));
        secondary = pos && !primary && (d_off < signed'({2'b00, r_window_ticks}))
                    && !shape_ok;
    end

    // ------------------------------------------------------------------
    // Digital edge events
    // ------------------------------------------------------------------
    always_comb begin
        risen     = r_s1.dig_word & ~r_prev_raw;
        stim      = |(risen & r_sync_mask);
        risen_clr = risen & ~r_sync_mask;
        dig_ev    = (risen_clr != r_prev_edge)
                    && ((r_dig_count == sasc_pkg::DIG_COUNT_SAT)
                        || (!stim && (r_s1.dig_word != r_prev_edge)));
    end

    assign is_spike = (r_s1.cmd == sasc_pkg::CMD_SPIKE);

    // ------------------------------------------------------------------
    // Result assembly
    // ------------------------------------------------------------------
    always_comb begin
        res_a.out_time = r_s1.event_time;
        res_a.channel  = r_s1.channel;
        res_b.kind     = sasc_pkg::KIND_DIGITAL;
        res_b.rej      = sasc_pkg::REJ_NONE;
        res_b.out_time = r_s1.event_time;
        res_b.channel  = r_s1.channel;
        res_b.unit     = '0;
        res_b.word     = r_s1.dig_word;
        res_b.last     = 1'b1;
        if (is_spike) begin
            res_a.unit = r_s1.unit;
            res_a.word = '0;
            res_a.last = 1'b1;
            if (primary) begin
                res_a.kind = sasc_pkg::KIND_REJECT;
                res_a.rej  = sasc_pkg::REJ_PRIMARY;
            end else if (secondary) begin
                res_a.kind = sasc_pkg::KIND_REJECT;
                res_a.rej  = sasc_pkg::REJ_SECONDARY;
            end else begin
                res_a.kind = sasc_pkg::KIND_ACCEPT;
                res_a.rej  = sasc_pkg::REJ_NONE;
            end
            two_res = 1'b0;
            any_res = 1'b1;
        end else begin
            res_a.unit = '0;
            res_a.word = r_s1.dig_word;
            res_a.rej  = sasc_pkg::REJ_NONE;
            res_a.kind = stim ? sasc_pkg::KIND_SYNC : sasc_pkg::KIND_DIGITAL;
            res_a.last = !(stim && dig_ev);
            two_res    = stim && dig_ev;
            any_res    = stim || dig_ev;
        end
    end

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_ticks   <= sasc_pkg::BLANK_RST;
            r_window_ticks  <= sasc_pkg::WINDOW_RST;
            r_pre_ticks     <= sasc_pkg::PRE_RST;
            r_sync_mask     <= sasc_pkg::MASK_RST;
            r_artifact_time <= '0;
            r_prev_raw      <= '0;
            r_prev_edge     <= '0;
            r_dig_count     <= '0;
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_pend_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    sasc_pkg::CFG_BLANK_TICKS: begin
                        r_blank_ticks  <= i_cfg_wdata[sasc_pkg::BLANK_W-1:0];
                    end
                    sasc_pkg::CFG_WINDOW_TICKS: begin
                        r_window_ticks <= i_cfg_wdata[sasc_pkg::WINDOW_W-1:0];
                    end
                    sasc_pkg::CFG_PRE_TICKS: begin
                        r_pre_ticks    <= i_cfg_wdata[sasc_pkg::PRE_W-1:0];
                    end
                    sasc_pkg::CFG_SYNC_MASK: begin
                        r_sync_mask    <= i_cfg_wdata[sasc_pkg::MASK_W-1:0];
                    end
                    default: ;
                endcase
            end

            if (s_accept) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end

            if (adv && !is_spike) begin
                r_prev_raw  <= r_s1.dig_word;
                r_prev_edge <= risen_clr;
                if (stim) begin
                    r_artifact_time <= r_s1.event_time;
                end
                if (r_dig_count != sasc_pkg::DIG_COUNT_SAT) begin
                    r_dig_count <= r_dig_count + 2'd1;
                end
            end

            if (adv) begin
                r_out_valid  <= any_res;
                r_pend_valid <= two_res;
            end else if (r_pend_valid && out_free) begin
                // move the second result of a digital word up
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (i_m_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1 <= n_s1;
        end
        if (adv) begin
            r_out  <= res_a;
            r_pend <= res_b;
        end else if (r_pend_valid && out_free) begin
            r_out  <= r_pend;
        end
    end

    // ------------------------------------------------------------------
    // Output packing
    // ------------------------------------------------------------------
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = OUT_W'({r_out.word, r_out.unit, r_out.channel, r_out.out_time,
                                r_out.rej});

endmodule

`default_nettype wire

// File: design/sasc_checker.sv
// ----------------------------------------------------------------------------
// sasc_checker: port-level checks on the classifier result stream
// Watches the master side only and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sasc_checker #(
    parameter int TIME_BITS = sasc_pkg::TIME_BITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_m_tvalid,
    input logic i_m_tready,
    input logic [((sasc_pkg::REJ_W + TIME_BITS + sasc_pkg::CHANNEL_W
                   + sasc_pkg::UNIT_W + sasc_pkg::WORD_W + 7) / 8) * 8 - 1:0] i_m_tdata,
    input logic [sasc_pkg::KIND_W-1:0] i_m_tuser,
    input logic                        i_m_tlast
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
                                      && $stable(i_m_tuser) && $stable(i_m_tlast))
        else $error("stalled result changed");

    // rejected kind and a nonzero reject code go together
    a_reject_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> ((i_m_tuser == sasc_pkg::KIND_REJECT)
                        == (i_m_tdata[sasc_pkg::REJ_W-1:0] != sasc_pkg::REJ_NONE)))
        else $error("reject code does not match result kind");

    // spike results are single, so always last
    a_spike_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && ((i_m_tuser == sasc_pkg::KIND_ACCEPT)
                       || (i_m_tuser == sasc_pkg::KIND_REJECT)) |-> i_m_tlast)
        else $error("spike result without last");

    // a sync event without last is followed by the digital event of the same word
    a_sync_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tready && (i_m_tuser == sasc_pkg::KIND_SYNC) && !i_m_tlast
        |=> i_m_tvalid && (i_m_tuser == sasc_pkg::KIND_DIGITAL) && i_m_tlast)
        else $error("sync event not followed by its digital event");

endmodule

bind stim_artifact_spike_classifier_core sasc_checker #(
    .TIME_BITS (TIME_BITS)
) u_sasc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);

`default_nettype wire
